/* rtl/core/nspc_pkg.sv */
// ----------------------------------------------------------------------------
// nspc_pkg
// Shared widths and types for the nearest-seed pixel color unit.
// ----------------------------------------------------------------------------
package nspc_pkg;

	localparam int IDX_BITS   = 6;
	localparam int CNT_BITS   = 7;
	localparam int COLOR_BITS = 8;
	localparam int RGB_BITS   = 3 * COLOR_BITS;
	localparam int DIST_BITS  = 26;

	// result tdata: red, green, blue, index, distance from bit 0 up
	localparam int M_TDATA_W  = 56;
	localparam int M_OFF_R    = 0;
	localparam int M_OFF_G    = M_OFF_R + COLOR_BITS;
	localparam int M_OFF_B    = M_OFF_G + COLOR_BITS;
	localparam int M_OFF_IDX  = M_OFF_B + COLOR_BITS;
	localparam int M_OFF_DIST = M_OFF_IDX + IDX_BITS;

	localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

	// item kind carried on s_tuser
	typedef enum logic {
		MODE_LOAD  = 1'b0,
		MODE_QUERY = 1'b1
	} mode_t;

	typedef logic [RGB_BITS-1:0] rgb_t;

endpackage

/* rtl/core/nspc_ram.sv */
// ----------------------------------------------------------------------------
// nspc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nspc_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* rtl/core/nearest_seed_pixel_color_unit.sv */
// One seed per cycle through the shared distance pipeline (RAM read, abs
// diff, squares, add/compare). The input stays blocked while a query scans
// and while a stalled result holds the output register; the next item is
// not taken before the query's result is moved into the output register.
// A load is written into the seed table and leaves the input ready.
// Reset (arst_n low) clears the count register, the sequencer and m_tvalid;
// the seed table is not cleared and holds no valid data until loaded.
// ----------------------------------------------------------------------------
// nearest_seed_pixel_color_unit
// Voronoi coloring: seed table load and brute-force nearest-seed search.
// ----------------------------------------------------------------------------
module nearest_seed_pixel_color_unit
	import nspc_pkg::*;
#(
	parameter int MAX_SEEDS  = 64,   // 1..64
	parameter int COORD_BITS = 12    // 4..16
) (
	input  logic clk,
	input  logic arst_n,
	// s_tdata: seed_index, coord_x, coord_y, seed_red, seed_green, seed_blue
	input  logic                                        s_tvalid,
	output logic                                        s_tready,
	input  logic [((IDX_BITS + 2*COORD_BITS + RGB_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	input  logic                                        s_tuser,   // mode
	// m_tdata: pixel_red, pixel_green, pixel_blue, nearest_index,
	//          nearest_distance
	output logic                                        m_tvalid,
	input  logic                                        m_tready,
	output logic [M_TDATA_W-1:0]                        m_tdata,
	output logic                                        m_tuser,   // found
	input  logic                                        cfg_valid,
	output logic                                        cfg_ready,
	input  logic [CNT_BITS-1:0]                         cfg_data
);

	localparam int AW     = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
	localparam int WORD_W = 2 * COORD_BITS + RGB_BITS;
	localparam int SQ_W   = 2 * COORD_BITS;
	localparam int SUM_W  = SQ_W + 1;
	localparam int DW     = (SUM_W > DIST_BITS) ? SUM_W : DIST_BITS;
	localparam int OFF_X  = IDX_BITS;
	localparam int OFF_Y  = OFF_X + COORD_BITS;
	localparam int OFF_C  = OFF_Y + COORD_BITS;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t                 state_q;
	logic [CNT_BITS-1:0]    cfg_count_q;
	logic [CNT_BITS-1:0]    count_q;
	logic [CNT_BITS-1:0]    issue_q;
	logic [COORD_BITS-1:0]  px_q;
	logic [COORD_BITS-1:0]  py_q;
	logic [DIST_BITS-1:0]   best_dist_q;
	logic [IDX_BITS-1:0]    best_idx_q;
	rgb_t                   best_color_q;
	logic                   found_q;
	logic                   m_tvalid_q;
	logic [M_TDATA_W-1:0]   m_tdata_q;
	logic                   m_tuser_q;

	logic                   in_accept;
	logic                   is_query;
	logic [IDX_BITS-1:0]    in_idx;
	logic [COORD_BITS-1:0]  in_x;
	logic [COORD_BITS-1:0]  in_y;
	rgb_t                   in_rgb;
	logic                   wr_en;
	logic [CNT_BITS-1:0]    count_sat;
	logic                   issue_en;
	logic                   issue_last;
	logic [WORD_W-1:0]      rd_data;

	// distance pipeline
	logic                   v_s1, v_s2, v_s3;
	logic                   last_s1, last_s2, last_s3;
	logic [IDX_BITS-1:0]    idx_s1, idx_s2, idx_s3;
	rgb_t                   color_s2, color_s3;
	logic [COORD_BITS-1:0]  dx_s2, dy_s2;
	logic [SQ_W-1:0]        sqx_s3, sqy_s3;

	logic [COORD_BITS-1:0]  rd_x, rd_y;
	logic [SQ_W-1:0]        dxe, dye;
	logic [DW-1:0]          dist_sum;
	logic [DIST_BITS-1:0]   dist_sat;
	logic                   take_new;
	logic                   out_free;

	assign in_idx = s_tdata[0 +: IDX_BITS];
	assign in_x   = s_tdata[OFF_X +: COORD_BITS];
	assign in_y   = s_tdata[OFF_Y +: COORD_BITS];
	assign in_rgb = s_tdata[OFF_C +: RGB_BITS];

	assign s_tready  = (state_q == ST_IDLE);
	assign in_accept = s_tvalid && s_tready;
	assign is_query  = (mode_t'(s_tuser) == MODE_QUERY);
	assign wr_en     = in_accept && !is_query &&
	                   ({1'b0, in_idx} < CNT_BITS'(MAX_SEEDS));
	assign count_sat = (cfg_count_q > CNT_BITS'(MAX_SEEDS)) ? CNT_BITS'(MAX_SEEDS) : cfg_count_q;
	assign cfg_ready = 1'b1;

	assign issue_en   = (state_q == ST_SCAN) && (issue_q < count_q);
	assign issue_last = (issue_q == count_q - CNT_BITS'(1));

	nspc_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAX_SEEDS)
	) u_seed_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(in_idx[AW-1:0]),
		.wr_data({in_rgb, in_y, in_x}),
		.rd_en  (issue_en),
		.rd_addr(issue_q[AW-1:0]),
		.rd_data(rd_data)
	);

	assign rd_x = rd_data[0 +: COORD_BITS];
	assign rd_y = rd_data[COORD_BITS +: COORD_BITS];
	assign dxe  = SQ_W'(dx_s2);
	assign dye  = SQ_W'(dy_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= issue_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1   <= issue_q[IDX_BITS-1:0];
		last_s1  <= issue_last;
		idx_s2   <= idx_s1;
		last_s2  <= last_s1;
		color_s2 <= rd_data[2*COORD_BITS +: RGB_BITS];
		dx_s2    <= (px_q > rd_x) ? (px_q - rd_x) : (rd_x - px_q);
		dy_s2    <= (py_q > rd_y) ? (py_q - rd_y) : (rd_y - py_q);
		idx_s3   <= idx_s2;
		last_s3  <= last_s2;
		color_s3 <= color_s2;
		sqx_s3   <= dxe * dxe;
		sqy_s3   <= dye * dye;
	end

	assign dist_sum = DW'(sqx_s3) + DW'(sqy_s3);
	assign dist_sat = (dist_sum > DW'(DIST_MAX)) ? DIST_MAX : dist_sum[DIST_BITS-1:0];
	// strict less-than keeps the lowest index on ties
	assign take_new = !found_q || (dist_sat < best_dist_q);
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cfg_count_q  <= '0;
			count_q      <= '0;
			issue_q      <= '0;
			found_q      <= 1'b0;
			m_tvalid_q   <= 1'b0;
			px_q         <= '0;
			py_q         <= '0;
			best_dist_q  <= DIST_MAX;
			best_idx_q   <= '0;
			best_color_q <= '0;
			m_tdata_q    <= '0;
			m_tuser_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cfg_count_q <= cfg_data;
			end
			// drop the taken result unless a new one is loaded this cycle
			if (m_tvalid_q && m_tready && (state_q != ST_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept && is_query) begin
						px_q         <= in_x;
						py_q         <= in_y;
						count_q      <= count_sat;
						issue_q      <= '0;
						found_q      <= 1'b0;
						best_dist_q  <= DIST_MAX;
						best_idx_q   <= '0;
						best_color_q <= '0;
						state_q      <= (count_sat == '0) ? ST_DONE : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue_en) begin
						issue_q <= issue_q + CNT_BITS'(1);
					end
					if (v_s3) begin
						if (take_new) begin
							found_q      <= 1'b1;
							best_dist_q  <= dist_sat;
							best_idx_q   <= idx_s3;
							best_color_q <= color_s3;
						end
						if (last_s3) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					// hold the result until the output register is free
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tuser_q  <= found_q;
						// color keeps red in the low byte, as on s_tdata
						m_tdata_q  <= {best_dist_q, best_idx_q, best_color_q};
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

/* rtl/core/nspc_checker.sv */
// ----------------------------------------------------------------------------
// nspc_checker
// Port-level checks for the nearest-seed pixel color unit.
// ----------------------------------------------------------------------------
module nspc_checker
	import nspc_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 s_tuser,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic                 m_tuser
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// no seed found: black, index zero, distance all ones
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |->
			m_tdata[M_OFF_DIST +: DIST_BITS] == DIST_MAX &&
			m_tdata[M_OFF_DIST-1:0] == '0)
		else $error("empty result not black with full distance");

	// a query blocks the input while the scan runs
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser |=> !s_tready)
		else $error("input ready right after a query");

	// an item accepted with no result pending never raises a result next cycle
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid && s_tvalid && s_tready |=> !m_tvalid)
		else $error("result appeared one cycle after accept");

endmodule

bind nearest_seed_pixel_color_unit nspc_checker u_nspc_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
